// ===== design/mrss_pkg.sv =====
// ----------------------------------------------------------------------------
// mrss_pkg
// Shared types and constants of the Morton range split search block.
// ----------------------------------------------------------------------------
package mrss_pkg;

	localparam int unsigned TABLE_DEPTH_DFLT = 1024;
	localparam int unsigned CODE_W           = 32;
	localparam int unsigned SLOT_W           = 10;
	localparam int unsigned IDX_W            = 11;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_CHECK,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

// ===== design/mrss_req_if.sv =====
// ----------------------------------------------------------------------------
// mrss_req_if
// Request channel: table loads and split queries.
// ----------------------------------------------------------------------------
interface mrss_req_if;
	import mrss_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	slot_t slot;
	code_t code_value;
	slot_t range_start;
	idx_t  range_end;

	modport source (output valid, output operation, output slot, output code_value,
		output range_start, output range_end, input ready);
	modport sink (input valid, input operation, input slot, input code_value,
		input range_start, input range_end, output ready);
endinterface

// ===== design/mrss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrss_rsp_if
// Response channel: one beat per split query.
// ----------------------------------------------------------------------------
interface mrss_rsp_if;
	import mrss_pkg::*;

	logic  valid;
	logic  ready;
	slot_t split_index;
	logic  range_error;

	modport source (output valid, output split_index, output range_error, input ready);
	modport sink (input valid, input split_index, input range_error, output ready);
endinterface

// ===== design/mrss_table.sv =====
// ----------------------------------------------------------------------------
// mrss_table
// Code table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrss_table #(
	parameter int unsigned TABLE_DEPTH = mrss_pkg::TABLE_DEPTH_DFLT,
	parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  mrss_pkg::code_t       wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output mrss_pkg::code_t       rd_data
);
	import mrss_pkg::*;

	code_t mem [TABLE_DEPTH];
	code_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== design/mrss_search.sv =====
// ----------------------------------------------------------------------------
// mrss_search
// Query sequencer: for a non-empty range reads the end codes, then, unless they
// are equal, runs the binary search with one table read per step, and holds the result in the output register.
// ----------------------------------------------------------------------------
module mrss_search #(
	parameter int unsigned TABLE_DEPTH = mrss_pkg::TABLE_DEPTH_DFLT,
	parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	mrss_req_if.sink        req,
	mrss_rsp_if.source      rsp,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output mrss_pkg::code_t wr_data,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	input  mrss_pkg::code_t rd_data
);
	import mrss_pkg::*;

	state_t state_q, state_n;

	slot_t start_q;
	idx_t  end_q;
	code_t first_q;
	code_t mask_q;
	idx_t  lo_q, hi_q, mid_q, split_q;
	logic  err_q;

	logic  out_valid_q;
	slot_t out_split_q;
	logic  out_err_q;

	logic  accept, query, out_free, empty, same, hit, cont;
	idx_t  end_c, mid0, mid_eq, lo_n, hi_n, mid_n, split_n;
	code_t diff, smear, mask_c;
	logic [IDX_W:0] sum_eq, sum0, sum_n;

	assign accept   = req.valid && req.ready;
	assign query    = (req.operation == OP_QUERY);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		end_c  = (32'(req.range_end) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH) : req.range_end;
		empty  = (end_c <= {1'b0, req.range_start});

		same   = (first_q == rd_data);
		diff   = first_q ^ rd_data;
		smear  = diff | (diff >> 1);
		smear  = smear | (smear >> 2);
		smear  = smear | (smear >> 4);
		smear  = smear | (smear >> 8);
		smear  = smear | (smear >> 16);
		mask_c = ~(smear >> 1);
		sum_eq = {2'b00, start_q} + {1'b0, end_q};
		mid_eq = sum_eq[IDX_W:1];
		sum0   = {2'b00, start_q} + {1'b0, end_q} - (IDX_W+1)'(1);
		mid0   = sum0[IDX_W:1];

		hit    = (((first_q ^ rd_data) & mask_q) == '0);
		if (hit) begin
			split_n = mid_q;
			lo_n    = mid_q + IDX_W'(1);
			hi_n    = hi_q;
			cont    = (mid_q < hi_q);
		end else begin
			split_n = split_q;
			lo_n    = lo_q;
			hi_n    = mid_q - IDX_W'(1);
			cont    = (lo_q < mid_q);
		end
		sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n  = sum_n[IDX_W:1];
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && query) begin
					state_n = empty ? ST_DONE : ST_LAST;
				end
			end
			ST_LAST:   state_n = ST_CHECK;
			ST_CHECK:  state_n = same ? ST_DONE : ST_SEARCH;
			ST_SEARCH: state_n = cont ? ST_SEARCH : ST_DONE;
			ST_DONE:   state_n = out_free ? ST_IDLE : ST_DONE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = AW'(req.range_start);
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				rd_en     = accept && query && !empty;
			end
			ST_LAST: begin
				rd_en   = 1'b1;
				rd_addr = AW'(end_q - IDX_W'(1));
			end
			ST_CHECK: begin
				rd_en   = !same;
				rd_addr = AW'(mid0);
			end
			ST_SEARCH: begin
				rd_en   = cont;
				rd_addr = AW'(mid_n);
			end
			ST_DONE: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en   = accept && !query && (32'(req.slot) < TABLE_DEPTH);
	assign wr_addr = AW'(req.slot);
	assign wr_data = req.code_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && query) begin
					start_q <= req.range_start;
					end_q   <= end_c;
					split_q <= {1'b0, req.range_start};
					err_q   <= empty;
				end
			end
			ST_LAST: begin
				first_q <= rd_data;
			end
			ST_CHECK: begin
				mask_q  <= mask_c;
				lo_q    <= {1'b0, start_q};
				hi_q    <= end_q - IDX_W'(1);
				mid_q   <= mid0;
				split_q <= same ? mid_eq : {1'b0, start_q};
			end
			ST_SEARCH: begin
				lo_q    <= lo_n;
				hi_q    <= hi_n;
				mid_q   <= mid_n;
				split_q <= split_n;
			end
			ST_DONE: begin
				if (out_free) begin
					out_split_q <= SLOT_W'(split_q);
					out_err_q   <= err_q;
				end
			end
			default: begin
				err_q <= err_q;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.split_index = out_split_q;
	assign rsp.range_error = out_err_q;
endmodule

// ===== design/morton_range_split_search.sv =====
// ----------------------------------------------------------------------------
// morton_range_split_search
// Split finder for building a linear bounding volume hierarchy from a table
// of sorted 32-bit Morton codes.
// ----------------------------------------------------------------------------
// The req channel carries two kinds of beat. A load writes code_value into
// the table at slot and gives no response; loads outside the table are
// dropped. A query gives the range [range_start, range_end) and produces one
// rsp beat with split_index and range_error.
// Loads may follow each other in every cycle while no query is in progress.
// A query with an empty range goes straight to the done state and answers
// with range_error set. Otherwise the first end code is read as the query is
// taken and the last one in the LAST state, and the two are compared in the
// CHECK state; equal codes go straight to the done state, and else the binary
// search adds one table read per step, up to ceil(log2(range length + 1))
// steps. The single read port of the code table sets this pace.
// The block takes no new request beat while a query is in progress.
// The result waits in an output register, so a stalled receiver holds up a
// query only when a second result is ready before the first is taken; loads
// and further queries are accepted meanwhile.
// Reset clears the control state and the output valid; the table contents
// are undefined until written.
// ----------------------------------------------------------------------------
module morton_range_split_search #(
	parameter int unsigned TABLE_DEPTH = mrss_pkg::TABLE_DEPTH_DFLT
) (
	input  logic       clk,
	input  logic       arst_n,
	mrss_req_if.sink   req,
	mrss_rsp_if.source rsp
);
	import mrss_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	code_t         wr_data, rd_data;

	mrss_search #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mrss_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);
endmodule

// ===== design/mrss_checker.sv =====
// ----------------------------------------------------------------------------
// mrss_checker
// Port-level checks of the split search block, bound to its top level.
// ----------------------------------------------------------------------------
module mrss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input mrss_pkg::op_t      req_operation,
	input mrss_pkg::slot_t    req_range_start,
	input mrss_pkg::idx_t     req_range_end,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input mrss_pkg::slot_t    rsp_split_index,
	input logic               rsp_range_error
);
	import mrss_pkg::*;

	logic req_beat;
	assign req_beat = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_split_index)
			&& $stable(rsp_range_error))
		else $error("Response beat changed while stalled.");

	a_busy_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_operation == OP_QUERY |=> !req_ready)
		else $error("Request taken while a query is in progress.");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_operation == OP_LOAD && !rsp_valid |=> !rsp_valid)
		else $error("A load produced a response beat.");

	a_empty_range: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_operation == OP_QUERY && !rsp_valid
			&& req_range_end <= {1'b0, req_range_start}
		|-> ##2 (rsp_valid && rsp_range_error
			&& rsp_split_index == $past(req_range_start, 2)))
		else $error("Empty range did not answer with an error beat.");
endmodule

bind morton_range_split_search mrss_checker u_mrss_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_operation   (req.operation),
	.req_range_start (req.range_start),
	.req_range_end   (req.range_end),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_split_index (rsp.split_index),
	.rsp_range_error (rsp.range_error)
);

// ===== bench/tb_morton_range_split_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morton_range_split_search
// Self-checking bench for the Morton range split search block.
// ----------------------------------------------------------------------------
// Code loads and split queries are driven on the request channel with random
// gaps, and the response channel is stalled at random. A mirror of the code
// table follows every accepted load, and each accepted query has its split
// worked out against that mirror and queued. Every response beat is checked
// field by field against the oldest queued split. The table is filled
// completely before random queries start, so no unwritten entry is ever read.
// ----------------------------------------------------------------------------
module tb_morton_range_split_search;
	import mrss_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DFLT;
	localparam int END_MAX     = (1 << IDX_W) - 1;

	typedef struct packed {
		slot_t split_index;
		logic  range_error;
	} split_result_t;

	logic clk;
	logic arst_n;

	mrss_req_if req();
	mrss_rsp_if rsp();

	morton_range_split_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	code_t         code_mirror [TABLE_DEPTH];
	split_result_t pending_splits [$];
	int            mismatch_count = 0;
	int            items_sent     = 0;
	int            sender_calm    = 0;
	bit            steady         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d splits outstanding", pending_splits.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned prefix_length(input code_t a, input code_t b);
		code_t       diff;
		int unsigned n;
		diff = a ^ b;
		n = 0;
		for (int i = CODE_W - 1; i >= 0; i--) begin
			if (diff[i])
				return n;
			n++;
		end
		return n;
	endfunction

	function automatic split_result_t predict_split(input slot_t start_idx, input idx_t end_raw);
		split_result_t r;
		int            end_idx;
		int            lo;
		int            hi;
		int            mid;
		int unsigned   limit;
		code_t         first_code;
		code_t         last_code;
		end_idx = (int'(end_raw) > TABLE_DEPTH) ? TABLE_DEPTH : int'(end_raw);
		r.split_index = start_idx;
		r.range_error = 1'b0;
		if (end_idx <= int'(start_idx)) begin
			r.range_error = 1'b1;
			return r;
		end
		first_code = code_mirror[start_idx];
		last_code = code_mirror[end_idx - 1];
		if (first_code == last_code) begin
			r.split_index = slot_t'((int'(start_idx) + end_idx) >> 1);
		end else begin
			limit = prefix_length(first_code, last_code);
			lo = int'(start_idx);
			hi = end_idx - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (prefix_length(first_code, code_mirror[mid]) > limit) begin
					r.split_index = slot_t'(mid);
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		split_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_splits.size() == 0) begin
				report_mismatch("response beat with no query outstanding", rsp.split_index, 0);
			end else begin
				want = pending_splits.pop_front();
				if (rsp.split_index !== want.split_index)
					report_mismatch("split_index", rsp.split_index, want.split_index);
				if (rsp.range_error !== want.range_error)
					report_mismatch("range_error", rsp.range_error, want.range_error);
			end
		end
	end

	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		stall_left = 0;
		calm_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0 && !steady) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (steady || calm_left != 0) begin
				if (calm_left != 0)
					calm_left--;
				rsp.ready <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 50) == 0)
					calm_left = $urandom_range(20, 80);
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input op_t op, input slot_t slot, input code_t code,
			input slot_t start_idx, input idx_t end_idx);
		if (sender_calm != 0) begin
			sender_calm--;
		end else if (!steady && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end else if (!steady && $urandom_range(0, 40) == 0) begin
			sender_calm = $urandom_range(10, 40);
		end
		req.valid       <= 1'b1;
		req.operation   <= op;
		req.slot        <= slot;
		req.code_value  <= code;
		req.range_start <= start_idx;
		req.range_end   <= end_idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (op == OP_LOAD)
			code_mirror[slot] = code;
		else
			pending_splits.push_back(predict_split(start_idx, end_idx));
		items_sent++;
	endtask

	task automatic load_code(input int slot, input code_t code);
		send_beat(OP_LOAD, slot_t'(slot), code, slot_t'($urandom), idx_t'($urandom));
	endtask

	task automatic query_split(input int start_idx, input int end_idx);
		send_beat(OP_QUERY, slot_t'($urandom), code_t'($urandom), slot_t'(start_idx),
			idx_t'(end_idx));
	endtask

	task automatic wait_results_drained();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_splits.size() != 0);
	endtask

	// Writes n non-decreasing codes from base, never climbing more than span above it.
	task automatic load_sorted_run(input int lo, input int n, input code_t base,
			input code_t span);
		code_t code;
		code_t cap;
		code_t step_cap;
		case ($urandom_range(0, 3))
			0: cap = 3;
			1: cap = code_t'(1) << $urandom_range(0, 31);
			2: cap = 0;
			default: cap = span;
		endcase
		step_cap = span / code_t'(n);
		if (cap < step_cap)
			step_cap = cap;
		code = base;
		for (int i = 0; i < n; i++) begin
			load_code(lo + i, code);
			code += code_t'($urandom_range(0, step_cap));
		end
	endtask

	task automatic query_random_range();
		int start_idx;
		int end_idx;
		start_idx = $urandom_range(0, TABLE_DEPTH - 1);
		case ($urandom_range(0, 9))
			0: end_idx = $urandom_range(0, start_idx);
			1: end_idx = $urandom_range(TABLE_DEPTH, END_MAX);
			2: begin
				start_idx = $urandom_range(0, 3);
				end_idx = TABLE_DEPTH;
			end
			3: end_idx = start_idx + $urandom_range(1, TABLE_DEPTH);
			default: end_idx = start_idx + $urandom_range(1, 32);
		endcase
		query_split(start_idx, end_idx);
	endtask

	task automatic rewrite_window_and_query();
		int    n;
		int    lo;
		int    s;
		code_t base;
		n = $urandom_range(2, 24);
		lo = $urandom_range(0, TABLE_DEPTH - n);
		base = code_t'($urandom);
		load_sorted_run(lo, n, base, ~base);
		query_split(lo, lo + n);
		repeat ($urandom_range(1, 3)) begin
			s = lo + $urandom_range(0, n - 1);
			query_split(s, $urandom_range(s + 1, lo + n));
		end
	endtask

	task automatic test_directed_cases();
		load_code(0, 32'h0000_0000);
		load_code(1, 32'h0000_0000);
		load_code(2, 32'h0000_0001);
		load_code(3, 32'h7FFF_FFFF);
		load_code(4, 32'h8000_0000);
		load_code(5, 32'hFFFF_FFFF);
		load_code(1022, 32'hFFFF_FFFF);
		load_code(1023, 32'hFFFF_FFFF);
		query_split(0, 2);
		query_split(0, 6);
		query_split(2, 6);
		query_split(3, 5);
		query_split(4, 5);
		query_split(0, 0);
		query_split(5, 3);
		query_split(1023, 0);
		query_split(1023, 1023);
		query_split(1022, 1024);
		query_split(1023, 1024);
		query_split(1023, END_MAX);
		query_split(1022, 1025);
		wait_results_drained();
	endtask

	task automatic test_table_fill();
		for (int c = 0; c < TABLE_DEPTH / 64; c++)
			load_sorted_run(c * 64, 64, code_t'(c) << 28, 32'h0FFF_FFFF);
		query_split(0, TABLE_DEPTH);
		query_split(0, END_MAX);
		wait_results_drained();
	endtask

	task automatic test_random_mix(input int count);
		int goal;
		int slot;
		goal = items_sent + count;
		while (items_sent < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2: rewrite_window_and_query();
				3, 4, 5, 6: query_random_range();
				7: load_code($urandom_range(0, TABLE_DEPTH - 1), code_t'($urandom));
				default: begin
					slot = $urandom_range(1, TABLE_DEPTH - 2);
					load_code(slot, code_t'($urandom_range(code_mirror[slot - 1],
						code_mirror[slot + 1])));
				end
			endcase
			if ($urandom_range(0, 60) == 0)
				wait_results_drained();
		end
	endtask

	task automatic test_full_rate(input int count);
		int goal;
		steady = 1'b1;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 2) == 0)
				rewrite_window_and_query();
			else
				query_random_range();
		end
	endtask

	initial begin
		req.valid       <= 1'b0;
		req.operation   <= OP_LOAD;
		req.slot        <= '0;
		req.code_value  <= '0;
		req.range_start <= '0;
		req.range_end   <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_directed_cases();
		test_table_fill();
		test_random_mix(110);
		test_full_rate(40);
		wait_results_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
